/* hdl/lzssmf_pkg.sv */
// Package for the LZSS window match finder: sizes, request and result types,
// and the control group that drives the compare chain. Depends on nothing.
`default_nettype none

package lzssmf_pkg;

    localparam int WINDOW    = 4096;
    localparam int MAX_MATCH = 18;
    localparam int RING      = WINDOW + MAX_MATCH + 1;

    // Reads per search: the lookahead bytes, then one window pass plus the wrap.
    localparam int NREADS = WINDOW + 2 * MAX_MATCH - 1;

    localparam int PTR_W = $clog2(RING);
    localparam int IDX_W = $clog2(WINDOW);
    localparam int OFS_W = 12;
    localparam int LEN_W = 5;
    localparam int AVL_W = $clog2(MAX_MATCH + 2);
    localparam int RD_W  = $clog2(NREADS);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_last;
    } item_t;

    typedef struct packed {
        logic [OFS_W-1:0] match_offset;
        logic [LEN_W-1:0] match_length;
        logic             last_result;
    } result_t;

    typedef struct packed {
        logic             shift_la;
        logic             shift_win;
        logic             cand_valid;
        logic             cand_last;
        logic [IDX_W-1:0] cand_start;
    } chain_ctl_t;

    typedef struct packed {
        logic             valid;
        logic             last;
        logic [IDX_W-1:0] start;
        logic [LEN_W-1:0] length;
    } cand_t;

endpackage

`default_nettype wire

/* hdl/lzssmf_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; no package needed.
`default_nettype none

module lzssmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* hdl/lzssmf_cell.sv */
// One compare cell: holds a lookahead byte and a window byte, each shifted in
// from its neighbor, and flags when they are equal. Uses nothing else.
`default_nettype none

module lzssmf_cell (
    input  logic       clk,
    input  logic       shift_la,
    input  logic       shift_win,
    input  logic [7:0] la_in,
    input  logic [7:0] win_in,
    output logic [7:0] la_out,
    output logic [7:0] win_out,
    output logic       hit
);

    logic [7:0] la_reg;
    logic [7:0] win_reg;

    always_ff @(posedge clk)
    begin
        if (shift_la)
        begin
            la_reg <= la_in;
        end
        if (shift_win)
        begin
            win_reg <= win_in;
        end
    end

    assign la_out  = la_reg;
    assign win_out = win_reg;
    assign hit     = (la_reg == win_reg);

endmodule

`default_nettype wire

/* hdl/lzssmf_chain.sv */
// Row of compare cells plus the match-length encoder for one candidate start.
// Depends on lzssmf_pkg and lzssmf_cell.
`default_nettype none

module lzssmf_chain (
    input  logic                         clk,
    input  logic                         rst_n,
    input  lzssmf_pkg::chain_ctl_t       ctl,
    input  logic [lzssmf_pkg::LEN_W-1:0] lim,
    input  logic [7:0]                   din,
    output lzssmf_pkg::cand_t            res
);

    import lzssmf_pkg::*;

    logic [7:0]           la_q  [MAX_MATCH];
    logic [7:0]           win_q [MAX_MATCH];
    logic [MAX_MATCH-1:0] hit;

    logic             st_valid_reg;
    logic             st_last_reg;
    logic [IDX_W-1:0] st_start_reg;
    logic             res_valid_reg;
    logic             res_last_reg;
    logic [IDX_W-1:0] res_start_reg;
    logic [LEN_W-1:0] res_len_reg;
    logic [LEN_W-1:0] run_len;

    // New bytes enter the top cell, one step a cycle toward cell 0 while shifting.
    genvar k;
    generate
        for (k = 0; k < MAX_MATCH; k++)
        begin : g_cell
            if (k == MAX_MATCH - 1)
            begin : g_top
                lzssmf_cell u_cell (
                    .clk      (clk),
                    .shift_la (ctl.shift_la),
                    .shift_win(ctl.shift_win),
                    .la_in    (din),
                    .win_in   (din),
                    .la_out   (la_q[k]),
                    .win_out  (win_q[k]),
                    .hit      (hit[k])
                );
            end
            else
            begin : g_mid
                lzssmf_cell u_cell (
                    .clk      (clk),
                    .shift_la (ctl.shift_la),
                    .shift_win(ctl.shift_win),
                    .la_in    (la_q[k+1]),
                    .win_in   (win_q[k+1]),
                    .la_out   (la_q[k]),
                    .win_out  (win_q[k]),
                    .hit      (hit[k])
                );
            end
        end
    endgenerate

    // Length is the position of the first mismatch, with cells past the
    // usable lookahead counted as mismatches.
    always_comb
    begin
        run_len = LEN_W'(MAX_MATCH);
        for (int i = MAX_MATCH - 1; i >= 0; i--)
        begin
            if (!(hit[i] && (LEN_W'(i) < lim)))
            begin
                run_len = LEN_W'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_valid_reg  <= 1'b0;
            st_last_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
            res_last_reg  <= 1'b0;
        end
        else
        begin
            st_valid_reg  <= ctl.cand_valid;
            st_last_reg   <= ctl.cand_valid & ctl.cand_last;
            res_valid_reg <= st_valid_reg;
            res_last_reg  <= st_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        st_start_reg  <= ctl.cand_start;
        res_start_reg <= st_start_reg;
        res_len_reg   <= run_len;
    end

    assign res.valid  = res_valid_reg;
    assign res.last   = res_last_reg;
    assign res.start  = res_start_reg;
    assign res.length = res_len_reg;

endmodule

`default_nettype wire

/* hdl/lzss_window_match_finder_core.sv */
// Top level of the LZSS window match finder: history RAM, search sequencer,
// compare chain and result register. Depends on lzssmf_pkg, lzssmf_ram,
// lzssmf_chain.
//
//   channel  | handshake              | payload
//   ---------+------------------------+---------------------------------
//   item     | item_valid/item_stall  | data_byte, is_last
//   result   | result_valid/result_stall | match_offset, match_length, last_result
//   config   | cfg_wr_en              | cfg_wr_data (position base)
//
// During a search, one history RAM read per cycle feeds the cell row, and
// one candidate start per cycle. A request that causes no result is taken
// without leaving idle; no request is taken while a search or flush is
// running. A waiting result does not stop the next search, only its
// hand-off. Reset clears all control state; the history RAM is not
// cleared.
`default_nettype none

module lzss_window_match_finder_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    output logic                         item_stall,
    input  lzssmf_pkg::item_t            item,
    output logic                         result_valid,
    input  logic                         result_stall,
    output lzssmf_pkg::result_t          result,
    input  logic                         cfg_wr_en,
    input  logic [lzssmf_pkg::OFS_W-1:0] cfg_wr_data
);

    import lzssmf_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] seen_reg, seen_next;
    logic [IDX_W-1:0] emit_reg, emit_next;
    logic [OFS_W-1:0] pbase_reg;
    logic [PTR_W-1:0] pslot_reg, pslot_next;
    logic [PTR_W-1:0] wbase_reg;
    logic [AVL_W-1:0] avail_reg, avail_next;
    logic             flush_reg, flush_next;
    logic [LEN_W-1:0] lim_reg, lim_next;
    logic [RD_W-1:0]  rd_cnt_reg, rd_cnt_next;
    logic             rd_on_reg, rd_on_next;
    logic             s1_la_reg, s1_win_reg, s1_cand_reg, s1_last_reg;
    logic [IDX_W-1:0] s1_start_reg;
    logic [LEN_W-1:0] best_len_reg, best_len_next;
    logic [IDX_W-1:0] best_start_reg, best_start_next;
    logic             out_valid_reg, out_valid_next;
    result_t          out_reg, out_next;

    logic             item_accept;
    logic             start_job;
    logic [PTR_W-1:0] head_inc;
    logic [PTR_W-1:0] seen_inc;
    logic [AVL_W-1:0] flush_cnt;
    logic             fin;
    logic [PTR_W:0]   la_sum;
    logic [PTR_W-1:0] la_addr;
    logic [RD_W-1:0]  win_i;
    logic [IDX_W-1:0] win_idx;
    logic [PTR_W:0]   win_sum;
    logic [PTR_W-1:0] win_addr;
    logic [PTR_W-1:0] raddr;
    logic             rd_is_la;
    logic [OFS_W+1:0] ofs_sum;
    logic [7:0]       rdata;
    chain_ctl_t       ctl;
    cand_t            res;

    function automatic logic [PTR_W-1:0] ring_back(input logic [PTR_W-1:0] h,
                                                   input logic [AVL_W-1:0] n);
        logic [PTR_W:0] t;
        begin
            if (h >= PTR_W'(n))
            begin
                t = {1'b0, h} - (PTR_W+1)'(n);
            end
            else
            begin
                t = {1'b0, h} + (PTR_W+1)'(RING) - (PTR_W+1)'(n);
            end
            ring_back = t[PTR_W-1:0];
        end
    endfunction

    assign item_stall  = (state_reg != ST_IDLE);
    assign item_accept = item_valid & ~item_stall;

    assign head_inc  = (head_reg == PTR_W'(RING - 1)) ? '0 : head_reg + 1'b1;
    assign seen_inc  = (seen_reg == PTR_W'(RING)) ? seen_reg : seen_reg + 1'b1;
    assign flush_cnt = (seen_inc > PTR_W'(WINDOW)) ?
                       AVL_W'(seen_inc - PTR_W'(WINDOW)) : '0;
    assign fin       = flush_reg && (avail_reg == AVL_W'(1));

    // The lookahead bytes are read first, then the window from its oldest
    // byte, wrapping so every start sees MAX_MATCH following window bytes.
    assign rd_is_la = (rd_cnt_reg < RD_W'(MAX_MATCH));
    assign la_sum   = {1'b0, pslot_reg} + (PTR_W+1)'(rd_cnt_reg);
    assign la_addr  = (la_sum >= (PTR_W+1)'(RING)) ?
                      PTR_W'(la_sum - (PTR_W+1)'(RING)) : la_sum[PTR_W-1:0];
    assign win_i    = rd_cnt_reg - RD_W'(MAX_MATCH);
    assign win_idx  = (win_i >= RD_W'(WINDOW)) ?
                      IDX_W'(win_i - RD_W'(WINDOW)) : IDX_W'(win_i);
    assign win_sum  = {1'b0, wbase_reg} + (PTR_W+1)'(win_idx);
    assign win_addr = (win_sum >= (PTR_W+1)'(RING)) ?
                      PTR_W'(win_sum - (PTR_W+1)'(RING)) : win_sum[PTR_W-1:0];
    assign raddr    = rd_is_la ? la_addr : win_addr;

    assign ofs_sum = (OFS_W+2)'(best_start_reg) + (OFS_W+2)'(pbase_reg)
                   + (OFS_W+2)'(emit_reg);

    lzssmf_ram #(
        .WIDTH(8),
        .DEPTH(RING)
    ) u_ring (
        .clk  (clk),
        .we   (item_accept),
        .waddr(head_reg),
        .wdata(item.data_byte),
        .raddr(raddr),
        .rdata(rdata)
    );

    assign ctl.shift_la   = s1_la_reg;
    assign ctl.shift_win  = s1_win_reg;
    assign ctl.cand_valid = s1_cand_reg;
    assign ctl.cand_last  = s1_last_reg;
    assign ctl.cand_start = s1_start_reg;

    lzssmf_chain u_chain (
        .clk  (clk),
        .rst_n(rst_n),
        .ctl  (ctl),
        .lim  (lim_reg),
        .din  (rdata),
        .res  (res)
    );

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        seen_next       = seen_reg;
        emit_next       = emit_reg;
        pslot_next      = pslot_reg;
        avail_next      = avail_reg;
        flush_next      = flush_reg;
        lim_next        = lim_reg;
        rd_cnt_next     = rd_cnt_reg;
        rd_on_next      = rd_on_reg;
        best_len_next   = best_len_reg;
        best_start_next = best_start_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        start_job       = 1'b0;

        if (rd_on_reg)
        begin
            if (rd_cnt_reg == RD_W'(NREADS - 1))
            begin
                rd_on_next = 1'b0;
            end
            else
            begin
                rd_cnt_next = rd_cnt_reg + 1'b1;
            end
        end

        // Strictly longer only, so the lowest start wins a tie.
        if (res.valid && (res.length > best_len_reg))
        begin
            best_len_next   = res.length;
            best_start_next = res.start;
        end

        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (item_accept)
                begin
                    if (!item.is_last)
                    begin
                        head_next = head_inc;
                        seen_next = seen_inc;
                        if (seen_inc == PTR_W'(RING))
                        begin
                            avail_next = AVL_W'(MAX_MATCH + 1);
                            pslot_next = ring_back(head_inc, AVL_W'(MAX_MATCH + 1));
                            flush_next = 1'b0;
                            start_job  = 1'b1;
                        end
                    end
                    else
                    begin
                        head_next = '0;
                        seen_next = '0;
                        if (flush_cnt != '0)
                        begin
                            avail_next = flush_cnt;
                            pslot_next = ring_back(head_inc, flush_cnt);
                            flush_next = 1'b1;
                            start_job  = 1'b1;
                        end
                        else
                        begin
                            emit_next = '0;
                        end
                    end
                end
            end
            ST_RUN:
            begin
                if (res.valid && res.last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    out_valid_next        = 1'b1;
                    out_next.match_length = best_len_reg;
                    out_next.match_offset = (best_len_reg == '0) ? '0 :
                                            OFS_W'(ofs_sum % WINDOW);
                    out_next.last_result  = fin;
                    if (fin)
                    begin
                        emit_next = '0;
                    end
                    else
                    begin
                        emit_next = (emit_reg == IDX_W'(WINDOW - 1)) ? '0 :
                                    emit_reg + 1'b1;
                    end
                    if (flush_reg && !fin)
                    begin
                        avail_next = avail_reg - 1'b1;
                        pslot_next = (pslot_reg == PTR_W'(RING - 1)) ? '0 :
                                     pslot_reg + 1'b1;
                        start_job  = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (start_job)
        begin
            state_next    = ST_RUN;
            rd_cnt_next   = '0;
            rd_on_next    = 1'b1;
            best_len_next = '0;
            lim_next      = (avail_next > AVL_W'(MAX_MATCH)) ?
                            LEN_W'(MAX_MATCH) : LEN_W'(avail_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            seen_reg      <= '0;
            emit_reg      <= '0;
            pbase_reg     <= '0;
            avail_reg     <= '0;
            flush_reg     <= 1'b0;
            rd_cnt_reg    <= '0;
            rd_on_reg     <= 1'b0;
            s1_la_reg     <= 1'b0;
            s1_win_reg    <= 1'b0;
            s1_cand_reg   <= 1'b0;
            s1_last_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            seen_reg      <= seen_next;
            emit_reg      <= emit_next;
            avail_reg     <= avail_next;
            flush_reg     <= flush_next;
            rd_cnt_reg    <= rd_cnt_next;
            rd_on_reg     <= rd_on_next;
            s1_la_reg     <= rd_on_reg & rd_is_la;
            s1_win_reg    <= rd_on_reg & ~rd_is_la;
            s1_cand_reg   <= rd_on_reg & ~rd_is_la & (win_i >= RD_W'(MAX_MATCH - 1));
            s1_last_reg   <= rd_on_reg & (rd_cnt_reg == RD_W'(NREADS - 1));
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                pbase_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pslot_reg      <= pslot_next;
        wbase_reg      <= (pslot_reg >= PTR_W'(WINDOW)) ?
                          pslot_reg - PTR_W'(WINDOW) :
                          pslot_reg + PTR_W'(RING - WINDOW);
        lim_reg        <= lim_next;
        s1_start_reg   <= IDX_W'(win_i - RD_W'(MAX_MATCH - 1));
        best_len_reg   <= best_len_next;
        best_start_reg <= best_start_next;
        out_reg        <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

`default_nettype wire

/* tb/tb.sv */
// Testbench for lzss_window_match_finder_core: streams of bytes with random gaps and stalls,
// results checked against an in-bench longest-match predictor.
// Depends on lzssmf_pkg and the core RTL.
`timescale 1ns / 1ps

module tb;
    import lzssmf_pkg::*;

    localparam int LONG_HOLD    = 20000;
    localparam int SETTLE       = WINDOW + 2 * MAX_MATCH + 100;
    localparam int CYCLE_LIMIT  = 5000000;
    localparam int RAND_RESULTS = 45;

    typedef enum int {K_ZERO, K_ONES, K_SMALL, K_RAND, K_REPEAT} fill_kind_e;

    typedef struct {
        int         nbytes;
        fill_kind_e kind;
        int         base;
        bit         typed;
        int         t_off;
        int         t_len;
        int         mid_at;
        int         mid_base;
    } stream_row_t;

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_stall;
    item_t   item;
    logic    result_valid;
    logic    result_stall;
    result_t result;
    logic    cfg_wr_en;
    logic [OFS_W-1:0] cfg_wr_data;

    // Predictor state.
    logic [7:0] hist_ring [RING];
    int         hist_head;
    int         hist_count;
    int         emit_cnt;
    int         pos_base;

    result_t pending_matches[$];
    int      mismatches;
    int      results_seen;
    int      cycles;
    int      hold_asks;
    int      hold_seen;
    int      repeat_period;

    stream_row_t directed[6] = '{
        '{1,    K_RAND,  0,    0, 0,    0, -1,   0},
        '{4096, K_SMALL, 100,  0, 0,    0, -1,   0},
        '{4097, K_ZERO,  0,    1, 0,    1, -1,   0},
        '{4097, K_ONES,  4095, 1, 4095, 1, -1,   0},
        '{4136, K_SMALL, 2048, 0, 0,    0, 4130, 7},
        '{4101, K_RAND,  1,    0, 0,    0, -1,   0}
    };

    lzss_window_match_finder_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Brute-force longest match for the position in ring slot pslot.
    task automatic find_longest(input int pslot, input int avail, input bit fin);
        int lim, wbase, head_off, best_len, best_ofs, j;
        result_t r;
        lim = (avail < MAX_MATCH) ? avail : MAX_MATCH;
        wbase = (pslot + RING - WINDOW) % RING;
        head_off = (pos_base + emit_cnt) % WINDOW;
        best_len = 0;
        best_ofs = 0;
        for (int c = 0; c < WINDOW; c++)
        begin
            if (hist_ring[pslot] != hist_ring[(wbase + c) % RING])
                continue;
            j = 1;
            while (j < lim && hist_ring[(pslot + j) % RING] ==
                   hist_ring[(wbase + (c + j) % WINDOW) % RING])
                j++;
            if (j > best_len)
            begin
                best_len = j;
                best_ofs = (c + head_off) % WINDOW;
            end
            if (j >= MAX_MATCH)
                break;
        end
        r.match_offset = best_ofs[OFS_W-1:0];
        r.match_length = best_len[LEN_W-1:0];
        r.last_result  = fin;
        pending_matches.push_back(r);
        emit_cnt = (emit_cnt + 1) % WINDOW;
    endtask

    task automatic predict_byte(input logic [7:0] b, input bit last);
        int m;
        hist_ring[hist_head] = b;
        hist_head = (hist_head + 1) % RING;
        if (hist_count < RING)
            hist_count++;
        if (!last)
        begin
            if (hist_count == RING)
                find_longest((hist_head + RING - (MAX_MATCH + 1)) % RING,
                             MAX_MATCH + 1, 0);
        end
        else
        begin
            m = (hist_count > WINDOW) ? hist_count - WINDOW : 0;
            for (int k = 0; k < m; k++)
                find_longest((hist_head + RING - (m - k)) % RING, m - k, k + 1 == m);
            hist_count = 0;
            hist_head = 0;
            emit_cnt = 0;
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] make_byte(input fill_kind_e kind, input int idx);
        case (kind)
            K_ZERO:   return 8'h00;
            K_ONES:   return 8'hFF;
            K_SMALL:  return 8'($urandom_range(0, 3));
            K_REPEAT: return 8'((idx % repeat_period) * 37 + 5);
            default:  return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b, input bit last, input bit typed,
                             input int t_off, input int t_len);
        int gap;
        result_t t;
        gap = pick_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item.data_byte <= b;
        item.is_last <= last;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        if (typed)
        begin
            // The predictor still tracks the stream; the typed value replaces its output.
            predict_byte(b, last);
            if (pending_matches.size() > 0)
                void'(pending_matches.pop_back());
            t.match_offset = t_off[OFS_W-1:0];
            t.match_length = t_len[LEN_W-1:0];
            t.last_result = last;
            pending_matches.push_back(t);
        end
        else
        begin
            predict_byte(b, last);
        end
    endtask

    // Drain all results, let the block settle, then write position_base.
    // The caller has already dropped item_valid.
    task automatic write_base(input int v);
        @(posedge clk);
        while (pending_matches.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_wr_data <= v[OFS_W-1:0];
        cfg_wr_en <= 1'b1;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        pos_base = v % WINDOW;
    endtask

    task automatic send_stream(input stream_row_t row, input bit hold);
        write_base(row.base);
        repeat_period = $urandom_range(2, 40);
        for (int i = 0; i < row.nbytes; i++)
        begin
            if (i == row.mid_at)
            begin
                item_valid <= 1'b0;
                write_base(row.mid_base);
            end
            if (hold && i == RING + 1)
                hold_asks++;
            send_byte(make_byte(row.kind, i), i == row.nbytes - 1,
                      row.typed && i == row.nbytes - 1, row.t_off, row.t_len);
        end
        item_valid <= 1'b0;
    endtask

    // Receiver: random stalls, quiet stretches, and the long hold-off on request.
    initial
    begin
        int hold_left;
        int quiet_left;
        int r;
        hold_left = 0;
        quiet_left = 0;
        result_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_seen != hold_asks)
            begin
                hold_seen = hold_asks;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else if (quiet_left > 0)
            begin
                quiet_left--;
                result_stall <= 1'b0;
            end
            else
            begin
                r = $urandom_range(0, 999);
                if (r < 5)
                    quiet_left = $urandom_range(50, 500);
                else if (r < 10)
                    hold_left = $urandom_range(20, 200);
                result_stall <= (r >= 10 && r < 300);
            end
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            results_seen <= results_seen + 1;
            if (pending_matches.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: off=%0d len=%0d last=%0b",
                             result.match_offset, result.match_length,
                             result.last_result);
            end
            else
            begin
                want = pending_matches.pop_front();
                if (want.match_offset !== result.match_offset
                    || want.match_length !== result.match_length
                    || want.last_result !== result.last_result)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"result mismatch: exp off=%0d len=%0d last=%0b, ",
                                  "got off=%0d len=%0d last=%0b"},
                                 want.match_offset, want.match_length, want.last_result,
                                 result.match_offset, result.match_length,
                                 result.last_result);
                end
            end
        end
    end

    initial
    begin
        stream_row_t row;
        int start_results;
        int r;
        clk = 1'b0;
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        cycles = 0;
        mismatches = 0;
        results_seen = 0;
        hold_asks = 0;
        hold_seen = 0;
        repeat_period = 4;
        hist_head = 0;
        hist_count = 0;
        emit_cnt = 0;
        pos_base = 0;
        for (int i = 0; i < RING; i++)
            hist_ring[i] = 8'h00;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_stream(directed[i], i == 4);

        start_results = results_seen;
        while (results_seen - start_results < RAND_RESULTS)
        begin
            r = $urandom_range(0, 9);
            row.kind = fill_kind_e'($urandom_range(0, 4));
            row.nbytes = (r < 2) ? $urandom_range(1, 50) : WINDOW + $urandom_range(1, 30);
            r = $urandom_range(0, 9);
            row.base = (r == 0) ? 0 : (r == 1) ? 4095 : $urandom_range(0, 4095);
            row.typed = 0;
            row.t_off = 0;
            row.t_len = 0;
            row.mid_at = -1;
            row.mid_base = 0;
            send_stream(row, 0);
            // Let the results of this stream come back before counting again.
            while (pending_matches.size() > 0)
                @(posedge clk);
        end

        while (pending_matches.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* files.f */
hdl/lzssmf_pkg.sv
hdl/lzssmf_ram.sv
hdl/lzssmf_cell.sv
hdl/lzssmf_chain.sv
hdl/lzss_window_match_finder_core.sv
tb/tb.sv
